>>> sv/tvsf_pkg.sv
// Shared types, codes and helpers of the typed value scan filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package tvsf_pkg;

  localparam logic [3:0] TY_I8  = 4'd0;
  localparam logic [3:0] TY_U8  = 4'd1;
  localparam logic [3:0] TY_I16 = 4'd2;
  localparam logic [3:0] TY_U16 = 4'd3;
  localparam logic [3:0] TY_I32 = 4'd4;
  localparam logic [3:0] TY_U32 = 4'd5;
  localparam logic [3:0] TY_I64 = 4'd6;
  localparam logic [3:0] TY_U64 = 4'd7;
  localparam logic [3:0] TY_F32 = 4'd8;
  localparam logic [3:0] TY_F64 = 4'd9;

  localparam logic [3:0] MD_EXACT     = 4'd0;
  localparam logic [3:0] MD_BETWEEN   = 4'd1;
  localparam logic [3:0] MD_GREATER   = 4'd2;
  localparam logic [3:0] MD_LESS      = 4'd3;
  localparam logic [3:0] MD_ANY       = 4'd4;
  localparam logic [3:0] MD_CHANGED   = 4'd5;
  localparam logic [3:0] MD_UNCHANGED = 4'd6;
  localparam logic [3:0] MD_UP        = 4'd7;
  localparam logic [3:0] MD_DOWN      = 4'd8;
  localparam logic [3:0] MD_UP_BY     = 4'd9;
  localparam logic [3:0] MD_DOWN_BY   = 4'd10;

  localparam logic [2:0] CFG_VALUE_TYPE    = 3'd0;
  localparam logic [2:0] CFG_COMPARE_MODE  = 3'd1;
  localparam logic [2:0] CFG_OPERAND_A     = 3'd2;
  localparam logic [2:0] CFG_OPERAND_B     = 3'd3;
  localparam logic [2:0] CFG_EXCLUDE_START = 3'd4;
  localparam logic [2:0] CFG_EXCLUDE_END   = 3'd5;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [3:0]  value_type;
    logic [3:0]  compare_mode;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
    logic [63:0] exclude_start;
    logic [63:0] exclude_end;
  } cfg_t;

  typedef struct packed {
    logic [63:0] addr;
    logic [63:0] cur;
    logic [63:0] prev;
    logic [63:0] hit_value;
    logic        reject;
  } item_t;

  function automatic logic [3:0] type_bytes(input logic [3:0] t);
    logic [3:0] b;
    begin
      unique case (t)
        TY_I8, TY_U8: b = 4'd1;
        TY_I16, TY_U16: b = 4'd2;
        TY_I32, TY_U32, TY_F32: b = 4'd4;
        TY_I64, TY_U64, TY_F64: b = 4'd8;
        default: b = 4'd0;
      endcase
      return b;
    end
  endfunction

  function automatic logic [63:0] bytes_mask(input logic [3:0] b);
    logic [63:0] m;
    begin
      unique case (b)
        4'd1: m = 64'h0000_0000_0000_00ff;
        4'd2: m = 64'h0000_0000_0000_ffff;
        4'd4: m = 64'h0000_0000_ffff_ffff;
        4'd8: m = 64'hffff_ffff_ffff_ffff;
        default: m = 64'h0;
      endcase
      return m;
    end
  endfunction

endpackage

`default_nettype wire

>>> sv/tvsf_front.sv
// Front end: accepts input words, masks the address, sizes the value and
// applies the exclusion window. Depends on tvsf_pkg.
`default_nettype none

module tvsf_front import tvsf_pkg::*; #(
  parameter int ADDR_BITS = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire cfg_t         cfg,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [191:0] in_tdata,  // slot_address, current_word, previous_word
  output logic              q_valid,
  input  wire logic         q_ready,
  output item_t             q_data
);

  localparam logic [63:0] AMASK = ~({64{1'b1}} << ADDR_BITS);

  logic        f_v_r, f_v_nxt;
  item_t       item_r;
  item_t       item;
  logic [3:0]  size;
  logic [64:0] span;
  logic        win;

  always_comb begin
    item.addr      = in_tdata[63:0] & AMASK;
    item.cur       = in_tdata[127:64];
    item.prev      = in_tdata[191:128];
    size           = type_bytes(cfg.value_type);
    item.hit_value = item.cur & bytes_mask(size);
    span           = {1'b0, item.addr} + {61'b0, size};
    win            = (cfg.exclude_start < cfg.exclude_end) &&
                     (item.addr < cfg.exclude_end) &&
                     (span > {1'b0, cfg.exclude_start});
    item.reject    = (size == 4'd0) || win;
  end

  assign in_tready = !f_v_r || q_ready;
  assign q_valid   = f_v_r;
  assign q_data    = item_r;

  always_comb begin
    f_v_nxt = f_v_r;
    if (in_tready) begin
      f_v_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else begin
      f_v_r <= f_v_nxt;
    end
    if (in_tvalid && in_tready) begin
      item_r <= item;
    end
  end

endmodule

`default_nettype wire

>>> sv/tvsf_queue.sv
// Short word queue between front and back end.
// Depends on tvsf_pkg for the item type and depth.
`default_nettype none

module tvsf_queue import tvsf_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push_valid,
  output logic       push_ready,
  input  wire item_t push_data,
  output logic       pop_valid,
  input  wire logic  pop_ready,
  output item_t      pop_data
);

  item_t            mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]     count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != QDEPTH[QAW:0]);
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QDEPTH[QAW:0]) else $error("queue count over depth");

  a_push_only: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count missed a push");

endmodule

`default_nettype wire

>>> sv/tvsf_back.sv
// Back end: integer and float compares, and a pipelined float add for the
// step modes, ending in the result register. Depends on tvsf_pkg.
`default_nettype none

module tvsf_back import tvsf_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire cfg_t         cfg,
  input  wire logic         q_valid,
  output logic              q_ready,
  input  wire item_t        q_data,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata,  // hit_address, hit_value
  output logic              out_tuser   // is_match
);

  localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [63:0] addr;
    logic [63:0] hv;
    logic [63:0] cur;
    logic        is64;
    logic        pre;
    logic        need_add;
    logic        reject;
    logic        tnan;
    logic        tinf;
    logic        tinf_s;
    logic        sgn;
  } ctx_t;

  typedef struct packed {
    logic               s;
    logic signed [12:0] e;
    logic [52:0]        m;
    logic               inf;
    logic               nan;
  } fp_t;

  function automatic logic [63:0] okey(input logic [63:0] x, input logic [63:0] m,
                                       input logic [63:0] sb, input logic sg);
    logic [63:0] y;
    begin
      y = x;
      if (sg) begin
        if ((x & sb) != 64'h0) y = x | ~m;
        y = y ^ SIGN64;
      end
      return y;
    end
  endfunction

  function automatic logic [63:0] falign(input logic [63:0] x, input logic w);
    return w ? x : {x[31:0], 32'h0};
  endfunction

  function automatic logic fnan(input logic [63:0] x, input logic w);
    return w ? ((&x[62:52]) && (x[51:0] != 52'h0)) : ((&x[62:55]) && (x[54:32] != 23'h0));
  endfunction

  function automatic logic [63:0] fkey(input logic [63:0] x);
    return x[63] ? ~x : (x | SIGN64);
  endfunction

  function automatic logic feq(input logic [63:0] x, input logic [63:0] y,
                               input logic nx, input logic ny);
    return !nx && !ny && ((x[62:0] == 63'h0 && y[62:0] == 63'h0) || x == y);
  endfunction

  function automatic logic flt(input logic [63:0] x, input logic [63:0] y,
                               input logic nx, input logic ny);
    return !nx && !ny && !(x[62:0] == 63'h0 && y[62:0] == 63'h0) && (fkey(x) < fkey(y));
  endfunction

  function automatic fp_t unpack(input logic [63:0] x, input logic w);
    fp_t f;
    logic all1, frz;
    begin
      if (w) begin
        f.s  = x[63];
        f.m  = {x[62:52] != 11'h0, x[51:0]};
        f.e  = (x[62:52] == 11'h0) ? -13'sd1022 : $signed({2'b00, x[62:52]}) - 13'sd1023;
        all1 = &x[62:52];
        frz  = (x[51:0] == 52'h0);
      end else begin
        f.s  = x[31];
        f.m  = {x[30:23] != 8'h0, x[22:0], 29'h0};
        f.e  = (x[30:23] == 8'h0) ? -13'sd126 : $signed({5'b0, x[30:23]}) - 13'sd127;
        all1 = &x[30:23];
        frz  = (x[22:0] == 23'h0);
      end
      f.inf = all1 && frz;
      f.nan = all1 && !frz;
      return f;
    end
  endfunction

  function automatic logic [6:0] lzc59(input logic [58:0] x);
    logic [6:0] n;
    begin
      n = 7'd59;
      for (int i = 0; i < 59; i++) begin
        if (x[i]) n = 7'(58 - i);
      end
      return n;
    end
  endfunction

  logic adv;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_v_r;
  logic v1_nxt;

  // stage 1 decode, compare and operand unpack
  logic [3:0]  vt, md;
  logic [63:0] m, sb, c, p, a, b, ck, pk, ak, bk;
  logic        sg, imatch, is64, isf, fmatch;
  logic [63:0] fc, fp, fa, fb;
  logic        nc, np, na, nb;
  fp_t         up, ua, big, sml;
  logic        pge;
  logic signed [12:0] dd;
  ctx_t        ctx1;

  always_comb begin
    vt  = cfg.value_type;
    md  = cfg.compare_mode;
    m   = bytes_mask(type_bytes(vt));
    sb  = m ^ (m >> 1);
    sg  = (vt < TY_F32) && !vt[0];
    c   = q_data.cur & m;
    p   = q_data.prev & m;
    a   = cfg.operand_a & m;
    b   = cfg.operand_b & m;
    ck  = okey(c, m, sb, sg);
    pk  = okey(p, m, sb, sg);
    ak  = okey(a, m, sb, sg);
    bk  = okey(b, m, sb, sg);
    unique case (md)
      MD_EXACT:     imatch = (ck == ak);
      MD_BETWEEN:   imatch = (ck >= ak) && (ck <= bk);
      MD_GREATER:   imatch = (ck > ak);
      MD_LESS:      imatch = (ck < ak);
      MD_ANY:       imatch = 1'b1;
      MD_CHANGED:   imatch = (c != p);
      MD_UNCHANGED: imatch = (c == p);
      MD_UP:        imatch = (ck > pk);
      MD_DOWN:      imatch = (ck < pk);
      MD_UP_BY:     imatch = !(sg && (a & sb) != 64'h0) && !(ck < pk) && (((c - p) & m) == a);
      MD_DOWN_BY:   imatch = !(sg && (a & sb) != 64'h0) && !(ck > pk) && (((p - c) & m) == a);
      default:      imatch = 1'b0;
    endcase

    is64 = (vt == TY_F64);
    isf  = (vt == TY_F32) || is64;
    fc   = falign(q_data.cur, is64);
    fp   = falign(q_data.prev, is64);
    fa   = falign(cfg.operand_a, is64);
    fb   = falign(cfg.operand_b, is64);
    nc   = fnan(fc, is64);
    np   = fnan(fp, is64);
    na   = fnan(fa, is64);
    nb   = fnan(fb, is64);
    unique case (md)
      MD_EXACT:     fmatch = feq(fc, fa, nc, na);
      MD_BETWEEN:   fmatch = (feq(fc, fa, nc, na) || flt(fa, fc, na, nc)) &&
                             (feq(fc, fb, nc, nb) || flt(fc, fb, nc, nb));
      MD_GREATER:   fmatch = flt(fa, fc, na, nc);
      MD_LESS:      fmatch = flt(fc, fa, nc, na);
      MD_ANY:       fmatch = 1'b1;
      MD_CHANGED:   fmatch = !feq(fc, fp, nc, np);
      MD_UNCHANGED: fmatch = feq(fc, fp, nc, np);
      MD_UP:        fmatch = flt(fp, fc, np, nc);
      MD_DOWN:      fmatch = flt(fc, fp, nc, np);
      default:      fmatch = 1'b0;
    endcase

    up = unpack(q_data.prev, is64);
    ua = unpack(cfg.operand_a, is64);
    if (md == MD_DOWN_BY) begin
      ua.s = !ua.s;
    end
    pge = (up.e > ua.e) || (up.e == ua.e && up.m >= ua.m);
    big = pge ? up : ua;
    sml = pge ? ua : up;
    dd  = big.e - sml.e;

    ctx1.addr     = q_data.addr;
    ctx1.hv       = q_data.hit_value;
    ctx1.cur      = q_data.cur;
    ctx1.is64     = is64;
    ctx1.pre      = isf ? fmatch : imatch;
    ctx1.need_add = isf && (md == MD_UP_BY || md == MD_DOWN_BY);
    ctx1.reject   = q_data.reject;
    ctx1.tnan     = up.nan || ua.nan || (up.inf && ua.inf && (up.s != ua.s));
    ctx1.tinf     = up.inf || ua.inf;
    ctx1.tinf_s   = up.inf ? up.s : ua.s;
    ctx1.sgn      = big.s;
  end

  ctx_t               ctx1_r, ctx2_r, ctx3_r, ctx4_r, ctx5_r;
  logic signed [12:0] be1_r, be2_r, be3_r, er4_r, er5_r;
  logic [52:0]        bm1_r, sm1_r;
  logic [11:0]        d1_r;
  logic               sub1_r, sub2_r;
  logic [57:0]        bw2_r, aw2_r;
  logic [58:0]        sum3_r, sum4_r, norm5_r;
  logic [6:0]         sh4_r;
  logic               zero4_r, zero5_r;

  // stage 2 align
  logic [5:0]  sh;
  logic [57:0] w, lost, aligned;

  always_comb begin
    sh      = (d1_r >= 12'd58) ? 6'd58 : d1_r[5:0];
    w       = {sm1_r, 5'b0};
    lost    = (58'd1 << sh) - 58'd1;
    aligned = (w >> sh) | {57'b0, (w & lost) != 58'h0};
  end

  // stage 3 add, stage 4 leading zeros
  logic [58:0]        sum3;
  logic [6:0]         lz, s4;
  logic signed [12:0] emin, maxs;

  always_comb begin
    sum3 = sub2_r ? ({1'b0, bw2_r} - {1'b0, aw2_r}) : ({1'b0, bw2_r} + {1'b0, aw2_r});
    lz   = lzc59(sum3_r);
    emin = ctx3_r.is64 ? -13'sd1022 : -13'sd126;
    maxs = be3_r + 13'sd1 - emin;
    s4   = ($signed({6'b0, lz}) > maxs) ? maxs[6:0] : lz;
  end

  // stage 6 round, pack and compare
  logic [52:0]        keep;
  logic               rb, st, inc, carry, nbit, ovf, add_eq, match;
  logic [53:0]        r;
  logic [52:0]        mant;
  logic signed [12:0] e6, emax, bias, biased;
  logic [63:0]        packed_v, inf_t, inf_o, cm;
  logic               cz;

  always_comb begin
    if (ctx5_r.is64) begin
      keep = norm5_r[58:6];
      rb   = norm5_r[5];
      st   = norm5_r[4:0] != 5'h0;
    end else begin
      keep = {29'b0, norm5_r[58:35]};
      rb   = norm5_r[34];
      st   = norm5_r[33:0] != 34'h0;
    end
    inc    = rb && (st || keep[0]);
    r      = {1'b0, keep} + {53'b0, inc};
    carry  = ctx5_r.is64 ? r[53] : r[24];
    mant   = carry ? r[53:1] : r[52:0];
    e6     = er5_r + $signed({12'b0, carry});
    nbit   = ctx5_r.is64 ? mant[52] : mant[23];
    emax   = ctx5_r.is64 ? 13'sd1023 : 13'sd127;
    bias   = emax;
    ovf    = e6 > emax;
    biased = nbit ? e6 + bias : 13'sd0;
    if (ctx5_r.is64) begin
      packed_v = {ctx5_r.sgn, biased[10:0], mant[51:0]};
      inf_t    = {ctx5_r.tinf_s, 11'h7ff, 52'h0};
      inf_o    = {ctx5_r.sgn, 11'h7ff, 52'h0};
      cm       = ctx5_r.cur;
      cz       = ctx5_r.cur[62:0] == 63'h0;
    end else begin
      packed_v = {32'h0, ctx5_r.sgn, biased[7:0], mant[22:0]};
      inf_t    = {32'h0, ctx5_r.tinf_s, 8'hff, 23'h0};
      inf_o    = {32'h0, ctx5_r.sgn, 8'hff, 23'h0};
      cm       = {32'h0, ctx5_r.cur[31:0]};
      cz       = ctx5_r.cur[30:0] == 31'h0;
    end
    priority if (ctx5_r.tnan) begin
      add_eq = 1'b0;
    end else if (ctx5_r.tinf) begin
      add_eq = (cm == inf_t);
    end else if (zero5_r) begin
      add_eq = cz;
    end else if (ovf) begin
      add_eq = (cm == inf_o);
    end else begin
      add_eq = (cm == packed_v);
    end
    match = !ctx5_r.reject && (ctx5_r.need_add ? add_eq : ctx5_r.pre);
  end

  logic [127:0] out_data_r;
  logic         out_match_r;
  logic         out_v_nxt;

  assign adv        = !out_v_r || out_tready;
  assign q_ready    = adv;
  assign v1_nxt     = q_valid;
  assign out_v_nxt  = v5_r;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_match_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      v5_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      v1_r    <= v1_nxt;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
      v5_r    <= v4_r;
      out_v_r <= out_v_nxt;
    end
    if (adv) begin
      ctx1_r      <= ctx1;
      be1_r       <= big.e;
      bm1_r       <= big.m;
      sm1_r       <= sml.m;
      d1_r        <= dd[11:0];
      sub1_r      <= (big.s != sml.s);
      ctx2_r      <= ctx1_r;
      be2_r       <= be1_r;
      bw2_r       <= {bm1_r, 5'b0};
      aw2_r       <= aligned;
      sub2_r      <= sub1_r;
      ctx3_r      <= ctx2_r;
      be3_r       <= be2_r;
      sum3_r      <= sum3;
      ctx4_r      <= ctx3_r;
      sum4_r      <= sum3_r;
      sh4_r       <= s4;
      er4_r       <= be3_r + 13'sd1 - $signed({6'b0, s4});
      zero4_r     <= (sum3_r == 59'h0);
      ctx5_r      <= ctx4_r;
      norm5_r     <= sum4_r << sh4_r;
      er5_r       <= er4_r;
      zero5_r     <= zero4_r;
      out_data_r  <= {ctx5_r.hv, ctx5_r.addr};
      out_match_r <= match;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v5_r && !adv) |=> v5_r) else $error("pipeline dropped a word while stalled");

  a_reject_nomatch: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && v5_r && ctx5_r.reject) |=> !out_match_r)
    else $error("rejected word reported as match");

endmodule

`default_nettype wire

>>> sv/typed_value_scan_filter.sv
// Throughput: one word per cycle unless the output stalls; the float step add runs
// as a 6-stage pipe (unpack, align, add, leading-zero count, normalize, round)
// behind a 4-word queue.
// Reset: configuration returns to type i8, mode any, operands and window zero;
// the front register, queue and pipeline are emptied. Configuration is always ready.
`default_nettype none

module typed_value_scan_filter import tvsf_pkg::*; #(
  parameter int ADDR_BITS = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [63:0]  cfg_data,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [191:0] in_tdata,   // slot_address, current_word, previous_word
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata,  // hit_address, hit_value
  output logic              out_tuser   // is_match
);

  cfg_t  cfg_r;
  logic  fq_valid, fq_ready, qb_valid, qb_ready;
  item_t fq_data, qb_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.value_type    <= TY_I8;
      cfg_r.compare_mode  <= MD_ANY;
      cfg_r.operand_a     <= '0;
      cfg_r.operand_b     <= '0;
      cfg_r.exclude_start <= '0;
      cfg_r.exclude_end   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_VALUE_TYPE:    cfg_r.value_type    <= cfg_data[3:0];
        CFG_COMPARE_MODE:  cfg_r.compare_mode  <= cfg_data[3:0];
        CFG_OPERAND_A:     cfg_r.operand_a     <= cfg_data;
        CFG_OPERAND_B:     cfg_r.operand_b     <= cfg_data;
        CFG_EXCLUDE_START: cfg_r.exclude_start <= cfg_data;
        CFG_EXCLUDE_END:   cfg_r.exclude_end   <= cfg_data;
        default: ;
      endcase
    end
  end

  tvsf_front #(.ADDR_BITS(ADDR_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (fq_valid),
    .q_ready   (fq_ready),
    .q_data    (fq_data)
  );

  tvsf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  tvsf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (qb_valid),
    .q_ready    (qb_ready),
    .q_data     (qb_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire
